/* rtl/pcp_pkg.sv */
// shared types and constants of the principal component projection unit
package pcp_pkg;

  // fixed field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned ACC_W  = 40;
  localparam int unsigned PROD_W = 2 * DATA_W;

  // input operation codes
  localparam logic OP_LOAD_COEF = 1'b0;
  localparam logic OP_ATTRIBUTE = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPUTE,
    ST_EMIT
  } state_t;

  // control travelling alongside a multiply-accumulate operand pair
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] comp;
  } mac_ctrl_t;

  // status coming back from the multiply-accumulate unit
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] comp;
    logic             busy;
  } mac_stat_t;

endpackage

/* rtl/pcp_mac.sv */
// shared multiplier with fixed-point rounding and saturation to the accumulator width
module pcp_mac #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pcp_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [pcp_pkg::DATA_W-1:0]  attr,
  input  logic signed [pcp_pkg::DATA_W-1:0]  coef,
  output pcp_pkg::mac_stat_t                 stat,
  output logic signed [pcp_pkg::ACC_W-1:0]   term
);

  localparam logic signed [pcp_pkg::PROD_W-1:0] ROUND_ADD =
    pcp_pkg::PROD_W'(1) << (FRACTION_BITS - 1);

  logic                               prod_valid;
  logic [pcp_pkg::IDX_W-1:0]          prod_comp;
  logic signed [pcp_pkg::PROD_W-1:0]  prod;
  logic                               term_valid;
  logic [pcp_pkg::IDX_W-1:0]          term_comp;
  logic signed [pcp_pkg::PROD_W-1:0]  rounded;
  logic signed [pcp_pkg::PROD_W-1:0]  shifted;
  logic [pcp_pkg::PROD_W-pcp_pkg::ACC_W:0] high_bits;
  logic signed [pcp_pkg::ACC_W-1:0]   term_next;

  // round half up, then clamp to the accumulator range
  always_comb begin
    rounded   = prod + ROUND_ADD;
    shifted   = rounded >>> FRACTION_BITS;
    high_bits = shifted[pcp_pkg::PROD_W-1:pcp_pkg::ACC_W-1];
    if (&high_bits || ~|high_bits) begin
      term_next = shifted[pcp_pkg::ACC_W-1:0];
    end else if (shifted[pcp_pkg::PROD_W-1]) begin
      term_next = {1'b1, {(pcp_pkg::ACC_W-1){1'b0}}};
    end else begin
      term_next = {1'b0, {(pcp_pkg::ACC_W-1){1'b1}}};
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      term_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.valid;
      term_valid <= prod_valid;
    end
  end

  // product and rounded term registers
  always_ff @(posedge clk) begin
    prod      <= attr * coef;
    prod_comp <= ctrl.comp;
    term      <= term_next;
    term_comp <= prod_comp;
  end

  assign stat.valid = term_valid;
  assign stat.comp  = term_comp;
  assign stat.busy  = prod_valid | term_valid;

endmodule

/* rtl/principal_component_projection_unit.sv */
// top level: coefficient store, accumulators, sequencer, stream and register ports
//
// A coefficient load goes into the store; the block stays idle. A record attribute
// has its coefficient column read from the store one entry a cycle and fed through
// the single shared multiplier, whose read, product and rounding stages drain into
// the accumulators; no item is taken until the last term is in, and the sequencer
// then returns to idle, or to emit on the last attribute of a record. A position
// outside the record adds nothing and leaves the block idle unless it ends the
// record. On the last attribute the DIMENSION components leave one a cycle while
// the output is taken; no item is taken until the last is in the output register.
// The missing level register sits at byte address 0 of the register port.
module principal_component_projection_unit #(
  parameter int unsigned DIMENSION     = 13,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position [7:0], value [39:8]
  input  logic [0:0]  s_tuser,   // operation [0]
  input  logic        s_tlast,   // record_end
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // component_index [3:0], component_value [35:4]
  output logic        m_tlast,   // last_component
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned COEF_N = DIMENSION * DIMENSION;
  localparam int unsigned AW     = $clog2(COEF_N);
  localparam int unsigned AIW    = $clog2(DIMENSION);
  localparam int unsigned CW     = $clog2(DIMENSION + 1);
  localparam int unsigned DW     = pcp_pkg::DATA_W;
  localparam int unsigned ACW    = pcp_pkg::ACC_W;

  // stream payload fields
  logic                      in_op;
  logic [pcp_pkg::POS_W-1:0] in_pos;
  logic signed [DW-1:0]      in_value;
  logic                      in_accept;
  logic                      coef_in_range;
  logic                      attr_in_range;

  // registers
  logic signed [DW-1:0]      missing_level;
  logic                      record_missing;
  logic                      record_last;
  logic signed [DW-1:0]      attr;
  logic [AW-1:0]             rd_addr;
  logic [CW-1:0]             rd_count;
  logic [CW-1:0]             out_count;
  logic signed [DW-1:0]      rd_data;
  pcp_pkg::mac_ctrl_t        rd_ctrl;
  logic signed [DW-1:0]      coef_mem [COEF_N];
  logic signed [ACW-1:0]     acc [DIMENSION];

  pcp_pkg::state_t           state;
  pcp_pkg::state_t           state_next;

  // sequencer outputs
  logic                      issue;
  logic                      emit_load;
  logic                      emit_done;
  logic                      compute_done;

  // multiply-accumulate path
  pcp_pkg::mac_stat_t        mac_stat;
  logic signed [ACW-1:0]     mac_term;
  logic signed [ACW:0]       acc_sum;
  logic signed [ACW-1:0]     acc_sat;
  logic signed [ACW-1:0]     out_acc;
  logic signed [DW-1:0]      out_value;
  logic                      cfg_write;

  assign in_pos        = s_tdata[pcp_pkg::POS_W-1:0];
  assign in_value      = s_tdata[pcp_pkg::POS_W +: DW];
  assign in_op         = s_tuser[0];
  assign in_accept     = s_tvalid & s_tready;
  assign coef_in_range = {1'b0, in_pos} < (pcp_pkg::POS_W + 1)'(COEF_N);
  assign attr_in_range = in_pos < pcp_pkg::POS_W'(DIMENSION);

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? missing_level : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      missing_level <= {1'b1, {(DW-1){1'b0}}};
    end else if (cfg_write) begin
      missing_level <= pwdata;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pcp_pkg::ST_IDLE: begin
        if (in_accept && in_op == pcp_pkg::OP_ATTRIBUTE) begin
          if (attr_in_range) begin
            state_next = pcp_pkg::ST_COMPUTE;
          end else if (s_tlast) begin
            state_next = pcp_pkg::ST_EMIT;
          end
        end
      end
      pcp_pkg::ST_COMPUTE: begin
        if (compute_done) begin
          state_next = record_last ? pcp_pkg::ST_EMIT : pcp_pkg::ST_IDLE;
        end
      end
      pcp_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_next = pcp_pkg::ST_IDLE;
        end
      end
      default: state_next = pcp_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready     = 1'b0;
    issue        = 1'b0;
    compute_done = 1'b0;
    emit_load    = 1'b0;
    emit_done    = 1'b0;
    unique case (state)
      pcp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      pcp_pkg::ST_COMPUTE: begin
        issue        = rd_count != CW'(DIMENSION);
        compute_done = (rd_count == CW'(DIMENSION)) & ~rd_ctrl.valid & ~mac_stat.busy;
      end
      pcp_pkg::ST_EMIT: begin
        emit_load = ~m_tvalid | m_tready;
        emit_done = emit_load & (out_count == CW'(DIMENSION - 1));
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // record flags, read counters and operand control
  always_ff @(posedge clk) begin
    if (rst) begin
      record_missing <= 1'b0;
      record_last    <= 1'b0;
      rd_count       <= '0;
      out_count      <= '0;
      rd_ctrl.valid  <= 1'b0;
    end else begin
      rd_ctrl.valid <= issue;
      if (issue) begin
        rd_ctrl.comp <= pcp_pkg::IDX_W'(rd_count);
      end
      if (in_accept && in_op == pcp_pkg::OP_ATTRIBUTE) begin
        record_last <= s_tlast;
        rd_count    <= '0;
        if (in_pos == '0 && in_value <= missing_level) begin
          record_missing <= 1'b1;
        end
      end else if (issue) begin
        rd_count <= rd_count + CW'(1);
      end
      if (emit_load) begin
        out_count <= emit_done ? '0 : out_count + CW'(1);
      end
      if (emit_done) begin
        record_missing <= 1'b0;
      end
    end
  end

  // attribute and read address
  always_ff @(posedge clk) begin
    if (in_accept && in_op == pcp_pkg::OP_ATTRIBUTE) begin
      attr    <= in_value;
      rd_addr <= in_pos[AW-1:0];
    end else if (issue) begin
      rd_addr <= rd_addr + AW'(DIMENSION);
    end
  end

  // coefficient store
  always_ff @(posedge clk) begin
    if (in_accept && in_op == pcp_pkg::OP_LOAD_COEF && coef_in_range) begin
      coef_mem[in_pos[AW-1:0]] <= in_value;
    end
    if (issue) begin
      rd_data <= coef_mem[rd_addr];
    end
  end

  pcp_mac #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rd_ctrl),
    .attr (attr),
    .coef (rd_data),
    .stat (mac_stat),
    .term (mac_term)
  );

  // saturating accumulate
  always_comb begin
    acc_sum = {acc[mac_stat.comp[AIW-1:0]][ACW-1], acc[mac_stat.comp[AIW-1:0]]}
            + {mac_term[ACW-1], mac_term};
    if (acc_sum[ACW] == acc_sum[ACW-1]) begin
      acc_sat = acc_sum[ACW-1:0];
    end else if (acc_sum[ACW]) begin
      acc_sat = {1'b1, {(ACW-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(ACW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIMENSION; i++) begin
        acc[i] <= '0;
      end
    end else if (mac_stat.valid) begin
      acc[mac_stat.comp[AIW-1:0]] <= acc_sat;
    end else if (emit_load) begin
      acc[out_count[AIW-1:0]] <= '0;
    end
  end

  // result value: missing level or accumulator clamped to 32 bits
  always_comb begin
    out_acc = acc[out_count[AIW-1:0]];
    if (record_missing) begin
      out_value = missing_level;
    end else if (&out_acc[ACW-1:DW-1] || ~|out_acc[ACW-1:DW-1]) begin
      out_value = out_acc[DW-1:0];
    end else if (out_acc[ACW-1]) begin
      out_value = {1'b1, {(DW-1){1'b0}}};
    end else begin
      out_value = {1'b0, {(DW-1){1'b1}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      m_tdata <= {4'b0000, out_value, pcp_pkg::IDX_W'(out_count)};
      m_tlast <= emit_done;
    end
  end

endmodule

/* tb/tb_top.sv */
// testbench of the principal component projection unit: stimulus, projection predictor, checks
module tb_top;

  localparam int unsigned DATA_W        = pcp_pkg::DATA_W;
  localparam int unsigned POS_W         = pcp_pkg::POS_W;
  localparam int unsigned IDX_W         = pcp_pkg::IDX_W;
  localparam int unsigned ACC_W         = pcp_pkg::ACC_W;
  localparam int unsigned DIMENSION     = 13;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned MATRIX_SIZE   = DIMENSION * DIMENSION;
  // settle time, with margin over the time one attribute occupies the block
  localparam int unsigned SETTLE_CYCLES = 2 * (DIMENSION + 5);
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 16;

  // register addresses: the missing level, and an address past the register list
  localparam logic [2:0] ADDR_MISSING_LEVEL = 3'd0;
  localparam logic [2:0] ADDR_UNUSED        = 3'd4;

  localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint OUT_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;

  typedef struct {
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } component_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;  // position [7:0], value [39:8]
  logic [0:0]  s_tuser  = '0;  // operation [0]
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // component_index [3:0], component_value [35:4]
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic signed [DATA_W-1:0] coef_matrix [MATRIX_SIZE];
  longint                   component_sums [DIMENSION];
  logic                     record_is_missing = 1'b0;
  logic signed [DATA_W-1:0] missing_level = Q_MIN;
  component_t               expected_components [$];

  int unsigned mismatch_count = 0;
  int unsigned tx_max = 15;
  int unsigned rx_max = 15;
  int unsigned hold_left = 0;
  int unsigned stall_draw;
  int unsigned quiet_cycles = 0;

  principal_component_projection_unit #(
    .DIMENSION     (DIMENSION),
    .FRACTION_BITS (FRACTION_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic longint saturate(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // signed random value spread over the given number of bits
  function automatic logic signed [DATA_W-1:0] scaled_random(int unsigned bits);
    return int'($urandom) >>> (32 - bits);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      default: return -32'sd1;
    endcase
  endfunction

  // attributes are mostly moderate so that sums stay in range, now and then full scale
  function automatic logic signed [DATA_W-1:0] pick_attribute();
    case ($urandom_range(0, 39))
      0: return $urandom;
      1: return pick_extreme();
      default: return scaled_random(24);
    endcase
  endfunction

  // eigenvector entries sit near unit magnitude, rarely full scale
  function automatic logic signed [DATA_W-1:0] pick_coefficient();
    if ($urandom_range(0, 31) == 0) return $urandom;
    return scaled_random(18);
  endfunction

  // projection predictor: applies one accepted item and queues the components it causes
  function automatic void project_item(logic op, logic [POS_W-1:0] pos,
                                       logic signed [DATA_W-1:0] val, logic rec_end);
    longint     prod;
    longint     rounded;
    int         c;
    component_t comp;
    if (op == pcp_pkg::OP_LOAD_COEF) begin
      if (pos < MATRIX_SIZE) coef_matrix[pos] = val;
      return;
    end
    if (pos < DIMENSION) begin
      if (pos == 0 && val <= missing_level) record_is_missing = 1'b1;
      for (c = 0; c < DIMENSION; c++) begin
        prod    = longint'(val) * longint'(coef_matrix[c * DIMENSION + pos]);
        rounded = (prod + (longint'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
        rounded = saturate(rounded, ACC_MIN, ACC_MAX);
        component_sums[c] = saturate(component_sums[c] + rounded, ACC_MIN, ACC_MAX);
      end
    end
    if (!rec_end) return;
    for (c = 0; c < DIMENSION; c++) begin
      comp.index   = IDX_W'(c);
      comp.value   = record_is_missing ? missing_level
                                       : DATA_W'(saturate(component_sums[c], OUT_MIN, OUT_MAX));
      comp.is_last = (c == DIMENSION - 1);
      expected_components.push_back(comp);
      component_sums[c] = 0;
    end
    record_is_missing = 1'b0;
  endfunction

  function automatic void check_component(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val,
                                          logic is_last);
    component_t want;
    if (expected_components.size() == 0) begin
      note_mismatch($sformatf("component %0d value %h arrived with none expected", idx, val));
      return;
    end
    want = expected_components.pop_front();
    if (idx !== want.index)
      note_mismatch($sformatf("component index: expected %0d, got %0d", want.index, idx));
    if (val !== want.value)
      note_mismatch($sformatf("component %0d value: expected %h, got %h",
                              want.index, want.value, val));
    if (is_last !== want.is_last)
      note_mismatch($sformatf("component %0d last flag: expected %b, got %b",
                              want.index, want.is_last, is_last));
  endfunction

  function automatic void check_level_readback(logic [31:0] readback);
    if (readback !== missing_level)
      note_mismatch($sformatf("missing level read: expected %h, got %h", missing_level, readback));
  endfunction

  // result side: check each item taken, then hold ready low for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (m_tvalid && m_tready) begin
      check_component(m_tdata[3:0], m_tdata[35:4], m_tlast);
      stall_draw = $urandom_range(0, rx_max);
      if (stall_draw != 0) begin
        m_tready  <= 1'b0;
        hold_left <= stall_draw - 1;
      end
    end else if (!m_tready) begin
      if (hold_left == 0) m_tready <= 1'b1;
      else hold_left <= hold_left - 1;
    end
  end

  // watchdog on cycles in which nothing moves
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("principal_component_projection_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // send one item after a drawn gap; valid stays high when the next item follows at once
  task automatic send_item(input logic op, input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val, input logic rec_end);
    int unsigned gap;
    gap = $urandom_range(0, tx_max);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, pos};
    s_tuser  <= op;
    s_tlast  <= rec_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    project_item(op, pos, val, rec_end);
  endtask

  // attributes at consecutive positions from a rotated start, record end on the last
  task automatic send_record(input logic signed [DATA_W-1:0] first_value,
                             input int unsigned count, input int unsigned rot);
    int unsigned      k;
    logic [POS_W-1:0] pos;
    for (k = 0; k < count; k++) begin
      pos = POS_W'((k + rot) % DIMENSION);
      send_item(pcp_pkg::OP_ATTRIBUTE, pos, (pos == 0) ? first_value : pick_attribute(),
                k == count - 1);
    end
  endtask

  // stop sending, let every expected component arrive and the block settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_components.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_MISSING_LEVEL) missing_level = data;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_register(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // reset value of the level, and a write past the register list leaves it alone
  task automatic test_register_port();
    logic [31:0] readback;
    read_register(ADDR_MISSING_LEVEL, readback);
    check_level_readback(readback);
    write_register(ADDR_UNUSED, $urandom);
    read_register(ADDR_MISSING_LEVEL, readback);
    check_level_readback(readback);
  endtask

  // whole matrix first, so no attribute ever reads an unwritten coefficient
  task automatic test_coefficient_load();
    int unsigned              i;
    int unsigned              row;
    int unsigned              col;
    logic signed [DATA_W-1:0] coef;
    for (i = 0; i < MATRIX_SIZE; i++) begin
      row = i / DIMENSION;
      col = i % DIMENSION;
      // first and last columns of the first two components carry full-scale weights
      if ((col == 0 || col == DIMENSION - 1) && row < 2) coef = (row == 0) ? Q_MAX : Q_MIN;
      else coef = pick_coefficient();
      send_item(pcp_pkg::OP_LOAD_COEF, POS_W'(i), coef, 1'b0);
    end
  endtask

  task automatic test_special_records();
    // full-scale attributes against full-scale weights saturate both stages
    send_item(pcp_pkg::OP_ATTRIBUTE, 8'd0, Q_MAX, 1'b0);
    send_item(pcp_pkg::OP_ATTRIBUTE, 8'd5, Q_MIN, 1'b0);
    send_item(pcp_pkg::OP_ATTRIBUTE, 8'd12, Q_MAX, 1'b1);
    // single-attribute records: a half-way rounding value and minus one lsb
    send_item(pcp_pkg::OP_ATTRIBUTE, 8'd12, 32'sh00008000, 1'b1);
    send_item(pcp_pkg::OP_ATTRIBUTE, 8'd7, -32'sd1, 1'b1);
    // first attribute exactly at the missing level
    send_item(pcp_pkg::OP_ATTRIBUTE, 8'd0, missing_level, 1'b0);
    send_item(pcp_pkg::OP_ATTRIBUTE, 8'd3, pick_attribute(), 1'b1);
    // positions outside the record add nothing but still end it
    send_item(pcp_pkg::OP_ATTRIBUTE, 8'd13, pick_attribute(), 1'b1);
    send_item(pcp_pkg::OP_ATTRIBUTE, 8'hFF, Q_MAX, 1'b1);
    // a repeated position is summed every time
    repeat (2) send_item(pcp_pkg::OP_ATTRIBUTE, 8'd4, pick_attribute(), 1'b0);
    send_item(pcp_pkg::OP_ATTRIBUTE, 8'd4, pick_attribute(), 1'b1);
    // record end on a load gives nothing, loads past the matrix are dropped
    send_item(pcp_pkg::OP_LOAD_COEF, 8'd100, pick_coefficient(), 1'b1);
    send_item(pcp_pkg::OP_LOAD_COEF, POS_W'(MATRIX_SIZE), Q_MAX, 1'b0);
    send_item(pcp_pkg::OP_LOAD_COEF, 8'hFF, Q_MIN, 1'b1);
    // zero first attribute
    send_item(pcp_pkg::OP_ATTRIBUTE, 8'd0, '0, 1'b0);
    send_item(pcp_pkg::OP_ATTRIBUTE, 8'd1, pick_attribute(), 1'b0);
    send_item(pcp_pkg::OP_ATTRIBUTE, 8'd12, pick_attribute(), 1'b1);
  endtask

  // records at, just above and away from a range of missing levels
  task automatic test_missing_level_settings();
    logic signed [DATA_W-1:0] levels [4];
    logic [31:0]              readback;
    int unsigned              n;
    levels = '{32'sd0, Q_MAX, scaled_random(24), Q_MIN};
    for (n = 0; n < 4; n++) begin
      wait_idle();
      write_register(ADDR_MISSING_LEVEL, levels[n]);
      read_register(ADDR_MISSING_LEVEL, readback);
      check_level_readback(readback);
      tx_max = (n % 2 == 0) ? 15 : 0;
      rx_max = (n < 2) ? 15 : 0;
      send_record(levels[n], 3, 0);
      send_record(levels[n] + 32'sd1, 3, 0);
      send_record(pick_attribute(), 3, 0);
    end
    tx_max = 15;
    rx_max = 15;
  endtask

  // mostly whole records with random content, the rest reloads and broken fragments
  task automatic test_random_stream();
    int unsigned      sent;
    int unsigned      count;
    int unsigned      j;
    logic [POS_W-1:0] pos;
    logic             drained;
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      // halfway: drain fully, then move the level into the usual attribute range
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        wait_idle();
        write_register(ADDR_MISSING_LEVEL, -32'sd4194304);
        drained = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: begin
          pos = ($urandom_range(0, 3) == 0) ? POS_W'($urandom)
                                            : POS_W'($urandom_range(0, MATRIX_SIZE - 1));
          send_item(pcp_pkg::OP_LOAD_COEF, pos, pick_coefficient(), 1'($urandom));
          sent++;
        end
        1: begin
          count = $urandom_range(1, 4);
          for (j = 0; j < count; j++)
            send_item(pcp_pkg::OP_ATTRIBUTE, POS_W'($urandom), pick_attribute(),
                      1'($urandom));
          sent += count;
        end
        default: begin
          count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, DIMENSION) : DIMENSION;
          send_record(($urandom_range(0, 7) == 0) ? missing_level : pick_attribute(),
                      count, $urandom_range(0, DIMENSION - 1));
          sent += count;
        end
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_port();
    test_coefficient_load();
    test_special_records();
    test_missing_level_settings();
    test_random_stream();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("principal_component_projection_unit verification clean");
    end else begin
      $display("principal_component_projection_unit verification failed");
    end
    $finish;
  end

endmodule

/* principal_component_projection_unit.f */
rtl/pcp_pkg.sv
rtl/pcp_mac.sv
rtl/principal_component_projection_unit.sv
tb/tb_top.sv
